[rtl/integer_to_radix_text_assert.svh]
// Assertion macros shared by the integer_to_radix_text RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`ifndef SYNTH
`define I2RT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define I2RT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define I2RT_ASSERT(label, clk, rst, prop, msg)
`define I2RT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/i2rt_pkg.sv]
// Shared types, constants and helpers for integer_to_radix_text.
// No dependencies; imported by every other file but the assert header.
package i2rt_pkg;

   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 8;
   localparam int RADIX_W  = 6;
   localparam int DIGIT_W  = 6;
   localparam int BITCNT_W = 5;
   localparam int UPC_W    = 3;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA   = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

   typedef logic [UPC_W-1:0] upc_type;

   // microprogram addresses
   localparam upc_type UA_IDLE    = 3'd0;
   localparam upc_type UA_DIVIDE  = 3'd1;
   localparam upc_type UA_STORE   = 3'd2;
   localparam upc_type UA_SIGN    = 3'd3;
   localparam upc_type UA_READ    = 3'd4;
   localparam upc_type UA_DIGIT   = 3'd5;
   localparam upc_type UA_NEWLINE = 3'd6;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIVIDE,
      OP_STORE,
      OP_READ
   } dp_op_type;

   // EM_MINUS emits only when the value is negative
   typedef enum logic [1:0] {
      EM_NONE,
      EM_MINUS,
      EM_DIGIT,
      EM_NEWLINE
   } emit_type;

   typedef enum logic [2:0] {
      JC_NEVER,
      JC_NO_REQ,
      JC_DIV_BUSY,
      JC_MORE_DIGITS,
      JC_DIGITS_LEFT,
      JC_ALWAYS
   } jump_cond_type;

   typedef struct packed {
      logic          take;
      dp_op_type     op;
      emit_type      emit;
      jump_cond_type jump;
      upc_type       target;
   } uword_type;

   typedef struct packed {
      dp_op_type op;
      emit_type  emit;
   } dp_ctl_type;

   typedef struct packed {
      logic negative;
      logic div_busy;
      logic more_digits;
      logic digits_left;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] over;
      over = d - DECIMAL_DIGITS;
      if (d < DECIMAL_DIGITS) begin
         return CHAR_ZERO + {2'b00, d};
      end
      return CHAR_ALPHA + {2'b00, over};
   endfunction

endpackage

[rtl/i2rt_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on i2rt_pkg for field widths.
interface i2rt_req_if import i2rt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface i2rt_rsp_if import i2rt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

[rtl/i2rt_sequencer.sv]
// Microprogram ROM, step counter and jump logic for integer_to_radix_text.
// Depends on i2rt_pkg.
module i2rt_sequencer import i2rt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          out_free,
   input  dp_status_type status,
   output logic          req_ready,
   output dp_ctl_type    ctl
);

   function automatic uword_type ucode(input upc_type addr);
      uword_type w;
      w = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, jump: JC_ALWAYS, target: UA_IDLE};
      unique case (addr)
         UA_IDLE: begin
            w = '{take: 1'b1, op: OP_LOAD, emit: EM_NONE, jump: JC_NO_REQ,
                  target: UA_IDLE};
         end
         UA_DIVIDE: begin
            w = '{take: 1'b0, op: OP_DIVIDE, emit: EM_NONE, jump: JC_DIV_BUSY,
                  target: UA_DIVIDE};
         end
         UA_STORE: begin
            w = '{take: 1'b0, op: OP_STORE, emit: EM_NONE, jump: JC_MORE_DIGITS,
                  target: UA_DIVIDE};
         end
         UA_SIGN: begin
            w = '{take: 1'b0, op: OP_NONE, emit: EM_MINUS, jump: JC_NEVER,
                  target: UA_IDLE};
         end
         UA_READ: begin
            w = '{take: 1'b0, op: OP_READ, emit: EM_NONE, jump: JC_NEVER,
                  target: UA_IDLE};
         end
         UA_DIGIT: begin
            w = '{take: 1'b0, op: OP_NONE, emit: EM_DIGIT, jump: JC_DIGITS_LEFT,
                  target: UA_READ};
         end
         UA_NEWLINE: begin
            w = '{take: 1'b0, op: OP_NONE, emit: EM_NEWLINE, jump: JC_ALWAYS,
                  target: UA_IDLE};
         end
         default: begin
            w = '{take: 1'b0, op: OP_NONE, emit: EM_NONE, jump: JC_ALWAYS,
                  target: UA_IDLE};
         end
      endcase
      return w;
   endfunction

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type word;
   logic      emit_need;
   logic      stall;
   logic      idle_wait;
   logic      taken;

   always_comb begin
      word = ucode(upc_ff);

      unique case (word.emit)
         EM_NONE:  emit_need = 1'b0;
         EM_MINUS: emit_need = status.negative;
         default:  emit_need = 1'b1;
      endcase

      stall     = emit_need && !out_free;
      idle_wait = word.take && !req_valid;
      req_ready = word.take;

      ctl.op   = (stall || idle_wait) ? OP_NONE : word.op;
      ctl.emit = (emit_need && !stall) ? word.emit : EM_NONE;

      unique case (word.jump)
         JC_NEVER:       taken = 1'b0;
         JC_NO_REQ:      taken = !req_valid;
         JC_DIV_BUSY:    taken = status.div_busy;
         JC_MORE_DIGITS: taken = status.more_digits;
         JC_DIGITS_LEFT: taken = status.digits_left;
         JC_ALWAYS:      taken = 1'b1;
         default:        taken = 1'b1;
      endcase

      if (stall) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = word.target;
      end else begin
         upc_in = upc_type'(upc_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

[rtl/i2rt_datapath.sv]
// Magnitude register, bit-serial radix divider, digit store and digit count.
// Depends on i2rt_pkg and integer_to_radix_text_assert.svh.
`include "integer_to_radix_text_assert.svh"
module i2rt_datapath import i2rt_pkg::*; #(
   parameter int DIGIT_DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_ctl_type                ctl,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [RADIX_W-1:0]        radix,
   output dp_status_type             status,
   output logic [DIGIT_W-1:0]        digit
);

   localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
   localparam int IDX_W = $clog2(DIGIT_DEPTH);

   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [BITCNT_W-1:0] bitcnt_ff, bitcnt_in;
   logic                negative_ff, negative_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    count_dec;
   logic [CNT_W:0]      count_inc;
   logic [DIGIT_W:0]    rem_shift;
   logic [DIGIT_W:0]    rem_diff;
   logic                fits;
   logic [DIGIT_W-1:0]  store [DIGIT_DEPTH];
   logic [DIGIT_W-1:0]  rd_ff;

   always_comb begin
      // one restoring-division step: shift in the next dividend bit
      rem_shift = {rem_ff, mag_ff[VALUE_W-1]};
      rem_diff  = rem_shift - {1'b0, radix};
      fits      = rem_shift >= {1'b0, radix};
      count_dec = count_ff - 1'b1;
      count_inc = {1'b0, count_ff} + 1'b1;

      mag_in      = mag_ff;
      rem_in      = rem_ff;
      bitcnt_in   = bitcnt_ff;
      negative_in = negative_ff;
      count_in    = count_ff;

      unique case (ctl.op)
         OP_LOAD: begin
            negative_in = value[VALUE_W-1];
            mag_in      = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
                                           : VALUE_W'(value);
            rem_in      = '0;
            bitcnt_in   = '1;
            count_in    = '0;
         end
         OP_DIVIDE: begin
            rem_in    = fits ? rem_diff[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
            mag_in    = {mag_ff[VALUE_W-2:0], fits};
            bitcnt_in = bitcnt_ff - 1'b1;
         end
         OP_STORE: begin
            rem_in   = '0;
            count_in = count_inc[CNT_W-1:0];
         end
         OP_READ: begin
            count_in = count_dec;
         end
         default: begin
         end
      endcase

      status.negative    = negative_ff;
      status.div_busy    = bitcnt_ff != '0;
      status.more_digits = (mag_ff != '0) && (count_inc < (CNT_W+1)'(DIGIT_DEPTH));
      status.digits_left = count_ff != '0;
      digit              = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         bitcnt_ff <= '0;
      end else begin
         count_ff  <= count_in;
         bitcnt_ff <= bitcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      negative_ff <= negative_in;
   end

   // digit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.op == OP_STORE) begin
         store[count_ff[IDX_W-1:0]] <= rem_ff;
      end
      if (ctl.op == OP_READ) begin
         rd_ff <= store[count_dec[IDX_W-1:0]];
      end
   end

   `I2RT_ASSERT_IMPL(a_store_after_full_divide, clock, reset, ctl.op == OP_STORE, bitcnt_ff == '1, "digit stored before division finished")
   `I2RT_ASSERT(a_count_in_range, clock, reset, count_ff <= CNT_W'(DIGIT_DEPTH), "digit count beyond store depth")
   `I2RT_ASSERT_IMPL(a_read_has_digit, clock, reset, ctl.op == OP_READ, count_ff != '0, "read from empty digit store")

endmodule

[rtl/integer_to_radix_text.sv]
// Top level of integer_to_radix_text: config register, output register, glue.
// Depends on i2rt_pkg, i2rt_if, i2rt_sequencer, i2rt_datapath and the assert header.
//
// Usage:
//  req_ch (valid/ready) carries one signed 32-bit value per transfer. rsp_ch
//  (valid/ready) returns its text one character per transfer: '-' when the
//  value is negative, the digits most significant first, then a newline with
//  last set. Zero renders as "0". csr_we/csr_wdata write the radix; values
//  below 2 act as 2 and above 36 act as 36. Write it only while idle.
//  Sequence: each item is accepted, then each digit takes a full pass of the
//  shared one-bit-per-cycle restoring divider and a store, then the sign step
//  (taken either way), a store read and an emit per digit, and the newline.
//  The block takes no new item while one is in progress; the next item is
//  accepted once the newline has been loaded into the output register.
//  Reset clears the microprogram counter, digit count, output valid and sets
//  radix to 10; the digit store is not cleared and needs no sweep.
//  A stalled receiver holds the output register and the microprogram waits at
//  the emitting step; nothing is dropped.
`include "integer_to_radix_text_assert.svh"
module integer_to_radix_text import i2rt_pkg::*; #(
   parameter int DIGIT_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [RADIX_W-1:0] csr_wdata,
   i2rt_req_if.sink           req_ch,
   i2rt_rsp_if.source         rsp_ch
);

   logic [RADIX_W-1:0] csr_radix_ff;
   logic [RADIX_W-1:0] radix_eff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;

   dp_ctl_type         ctl;
   dp_status_type      status;
   logic [DIGIT_W-1:0] digit;

   // radix register, saturated into the legal range
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_radix_ff <= RADIX_RESET;
      end else if (csr_we) begin
         csr_radix_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (csr_radix_ff < RADIX_MIN) begin
         radix_eff = RADIX_MIN;
      end else if (csr_radix_ff > RADIX_MAX) begin
         radix_eff = RADIX_MAX;
      end else begin
         radix_eff = csr_radix_ff;
      end
   end

   i2rt_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_ch.ready),
      .ctl       (ctl)
   );

   i2rt_datapath #(
      .DIGIT_DEPTH (DIGIT_DEPTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .value  (req_ch.value),
      .radix  (radix_eff),
      .status (status),
      .digit  (digit)
   );

   // output register: free when empty or draining this cycle
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (ctl.emit)
         EM_MINUS: begin
            rsp_char_in  = CHAR_MINUS;
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         EM_DIGIT: begin
            rsp_char_in  = digit_symbol(digit);
            rsp_last_in  = 1'b0;
            rsp_valid_in = 1'b1;
         end
         EM_NEWLINE: begin
            rsp_char_in  = CHAR_NEWLINE;
            rsp_last_in  = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.char_out = rsp_char_ff;
   assign rsp_ch.last     = rsp_last_ff;

   `I2RT_ASSERT_IMPL(a_transfer_loads, clock, reset, req_ch.valid && req_ch.ready, ctl.op == OP_LOAD, "request transfer without load")
   `I2RT_ASSERT_IMPL(a_emit_has_room, clock, reset, ctl.emit != EM_NONE, out_free, "character emitted over a pending one")
   `I2RT_ASSERT_IMPL(a_last_is_newline, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_char_ff == CHAR_NEWLINE, "last set on a non-newline character")

endmodule
